// File: rtl/gca_pkg.sv
// Shared types and constants for the greedy capacitated assigner.
// Operation codes, fixed field widths, and the controller/datapath interface structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gca_pkg;

  localparam int OP_W   = 2;
  localparam int IDX_W  = 6;
  localparam int FLD_W  = 20;
  localparam int DEM_W  = 16;
  localparam int CHG_W  = 21;
  localparam int TOT_W  = 32;

  typedef enum logic [OP_W-1:0] {
    OP_START = 2'd0,
    OP_LOAD  = 2'd1,
    OP_COST  = 2'd2
  } op_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;    // capture accepted word
    logic sweep;    // clear one row of the facility store
    logic start;    // clear running total and row search
    logic load;     // write facility row from latched word
    logic rd_item;  // read row addressed by latched index
    logic eval;     // compare latched cost element against best
    logic rd_best;  // read row of the current best facility
    logic commit;   // compute charge, write back opened row
    logic emit;     // update total, load result register
  } gca_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            last;
    logic            sweep_last;
    logic            out_busy;
  } gca_stat_t;

endpackage

`default_nettype wire

// File: rtl/greedy_capacitated_assigner_top.sv
// Top level of the greedy capacitated assigner.
// Instantiates gca_ctrl and gca_datapath; uses gca_pkg for widths and structs.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Input channel (in_*): one word per start, facility load or cost element.
//   A word is taken on a rising edge with in_valid high and in_stall low.
//   Result channel (out_*): one word per cost element flagged last_in_row,
//   taken on a rising edge with out_valid high and out_stall low.
// Sequence (states from acceptance until in_stall drops again)
//   start / load / unused op : DECODE (a load writes the store there)
//   cost element, not last    : DECODE + store read, EVAL (compare)
//   cost element, last        : DECODE, EVAL, CREAD, COMMIT, TOTAL; the result
//                                is registered when TOTAL emits into a free result register.
//   The steps follow from the facility store: a registered read
//   of the addressed row before the compare, then a read-modify-write of the
//   chosen row at commit, then the saturating total add.
// Reset
//   rst_n is synchronous, active low. After it the block sweeps the facility
//   store, one row per cycle until every row is cleared, with in_stall high;
//   every facility then reads as closed and the running total is zero.
// Backpressure
//   The result sits in an output register; while out_stall holds it, further
//   words are still taken, and only the next emit waits for the register.

module greedy_capacitated_assigner_top #(
  parameter int FACILITY_SLOTS = 64,
  parameter int COST_BITS      = 20
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [gca_pkg::OP_W-1:0]    in_operation,
  input  wire logic [gca_pkg::IDX_W-1:0]   in_facility_index,
  input  wire logic [gca_pkg::FLD_W-1:0]   in_capacity,
  input  wire logic [gca_pkg::FLD_W-1:0]   in_opening_cost,
  input  wire logic [gca_pkg::DEM_W-1:0]   in_demand,
  input  wire logic [gca_pkg::FLD_W-1:0]   in_assign_cost,
  input  wire logic                        in_last_in_row,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [gca_pkg::IDX_W-1:0]        out_chosen_facility,
  output logic                             out_found,
  output logic [gca_pkg::CHG_W-1:0]        out_charged_cost,
  output logic                             out_newly_opened,
  output logic [gca_pkg::TOT_W-1:0]        out_total_cost
);

  gca_pkg::gca_cmd_t  cmd;   // sequencing commands
  gca_pkg::gca_stat_t st;    // decoded op, row end, sweep end, result busy

  gca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  gca_datapath #(
    .FACILITY_SLOTS (FACILITY_SLOTS),
    .COST_BITS      (COST_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .st                  (st),
    .in_operation        (in_operation),
    .in_facility_index   (in_facility_index),
    .in_capacity         (in_capacity),
    .in_opening_cost     (in_opening_cost),
    .in_demand           (in_demand),
    .in_assign_cost      (in_assign_cost),
    .in_last_in_row      (in_last_in_row),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_chosen_facility (out_chosen_facility),
    .out_found           (out_found),
    .out_charged_cost    (out_charged_cost),
    .out_newly_opened    (out_newly_opened),
    .out_total_cost      (out_total_cost)
  );

endmodule

`default_nettype wire

// File: rtl/gca_ctrl.sv
// Controller for the greedy capacitated assigner: sequences each accepted word.
// Depends on gca_pkg (op codes, command and status structs).
`timescale 1ns / 1ps
`default_nettype none

module gca_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire gca_pkg::gca_stat_t st,
  output gca_pkg::gca_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_EVAL,
    S_CREAD,
    S_COMMIT,
    S_TOTAL
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r;

  assign in_stall = in_stall_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.sweep = 1'b1;
        if (st.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && !in_stall_r) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.rd_item = 1'b1;
        unique case (st.op)
          gca_pkg::OP_START: begin
            cmd.start = 1'b1;
            state_nxt = S_IDLE;
          end
          gca_pkg::OP_LOAD: begin
            cmd.load  = 1'b1;
            state_nxt = S_IDLE;
          end
          gca_pkg::OP_COST: begin
            state_nxt = S_EVAL;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = st.last ? S_CREAD : S_IDLE;
      end
      S_CREAD: begin
        cmd.rd_best = 1'b1;
        state_nxt   = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_TOTAL;
      end
      S_TOTAL: begin
        if (!st.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      in_stall_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= (state_nxt != S_IDLE);
    end
  end

  a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall_r |=> state_r == S_DECODE)
    else $error("accepted word not decoded next cycle");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !st.out_busy)
    else $error("result emitted over a held result");

  a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> in_stall_r && !cmd.latch)
    else $error("input taken during store clear");

endmodule

`default_nettype wire

// File: rtl/gca_datapath.sv
// Datapath for the greedy capacitated assigner: facility store, row search,
// commit arithmetic and result register. Depends on gca_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gca_datapath #(
  parameter int FACILITY_SLOTS = 64,
  parameter int COST_BITS      = 20
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire gca_pkg::gca_cmd_t           cmd,
  output gca_pkg::gca_stat_t               st,
  input  wire logic [gca_pkg::OP_W-1:0]    in_operation,
  input  wire logic [gca_pkg::IDX_W-1:0]   in_facility_index,
  input  wire logic [gca_pkg::FLD_W-1:0]   in_capacity,
  input  wire logic [gca_pkg::FLD_W-1:0]   in_opening_cost,
  input  wire logic [gca_pkg::DEM_W-1:0]   in_demand,
  input  wire logic [gca_pkg::FLD_W-1:0]   in_assign_cost,
  input  wire logic                        in_last_in_row,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [gca_pkg::IDX_W-1:0]        out_chosen_facility,
  output logic                             out_found,
  output logic [gca_pkg::CHG_W-1:0]        out_charged_cost,
  output logic                             out_newly_opened,
  output logic [gca_pkg::TOT_W-1:0]        out_total_cost
);

  localparam int AW = (FACILITY_SLOTS > 1) ? $clog2(FACILITY_SLOTS) : 1;
  localparam int CW = (COST_BITS < gca_pkg::FLD_W) ? COST_BITS : gca_pkg::FLD_W;
  localparam int RW = 2 * CW + 1;  // {open, opening cost, capacity}
  localparam int FW = gca_pkg::FLD_W;
  localparam int TW = gca_pkg::TOT_W;

  // latched word
  logic [gca_pkg::OP_W-1:0]  op_r;
  logic [gca_pkg::IDX_W-1:0] idx_r;
  logic [CW-1:0]             cap_r;
  logic [CW-1:0]             ocost_r;
  logic [gca_pkg::DEM_W-1:0] dem_r;
  logic [CW-1:0]             acost_r;
  logic                      last_r;

  // search and commit state
  logic [CW-1:0]  best_cost_r;
  logic [AW-1:0]  best_index_r;
  logic           best_valid_r;
  logic [TW-1:0]  total_r;
  logic [CW:0]    charge_r;
  logic           opened_r;
  logic [AW-1:0]  sweep_cnt_r;

  // facility store
  logic [RW-1:0]  mem [FACILITY_SLOTS];
  logic [RW-1:0]  rd_data_r;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [RW-1:0]  wr_data;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;

  // result register
  logic                      out_valid_r;
  logic [gca_pkg::IDX_W-1:0] out_chosen_r;
  logic                      out_found_r;
  logic [gca_pkg::CHG_W-1:0] out_charged_r;
  logic                      out_opened_r;
  logic [TW-1:0]             out_total_r;

  logic [31:0]   idx_ext;
  logic          in_range;
  logic [AW-1:0] item_addr;
  logic          rd_open;
  logic [CW-1:0] rd_ocost;
  logic [CW-1:0] rd_cap;
  logic          fits;
  logic          better;
  logic [FW-1:0] cap_diff;
  logic [CW-1:0] cap_new;
  logic [TW:0]   sum;
  logic [TW-1:0] total_new;

  assign idx_ext   = 32'(idx_r);
  assign in_range  = idx_ext < 32'(FACILITY_SLOTS);
  assign item_addr = idx_ext[AW-1:0];

  assign rd_open  = rd_data_r[RW-1];
  assign rd_ocost = rd_data_r[2*CW-1:CW];
  assign rd_cap   = rd_data_r[CW-1:0];

  assign fits   = in_range && (FW'(rd_cap) >= FW'(dem_r));
  assign better = !best_valid_r || (acost_r < best_cost_r);

  // saturating capacity update
  assign cap_diff = FW'(rd_cap) - FW'(dem_r);
  assign cap_new  = (FW'(rd_cap) >= FW'(dem_r)) ? cap_diff[CW-1:0] : '0;

  // saturating total
  assign sum       = {1'b0, total_r} + (TW + 1)'(charge_r);
  assign total_new = sum[TW] ? '1 : sum[TW-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = sweep_cnt_r;
    wr_data = '0;
    if (cmd.sweep) begin
      wr_en = 1'b1;
    end else if (cmd.load) begin
      wr_en   = in_range;
      wr_addr = item_addr;
      wr_data = {1'b0, ocost_r, cap_r};
    end else if (cmd.commit) begin
      wr_en   = best_valid_r;
      wr_addr = best_index_r;
      wr_data = {1'b1, rd_ocost, cap_new};
    end
  end

  assign rd_en   = cmd.rd_item || cmd.rd_best;
  assign rd_addr = cmd.rd_best ? best_index_r : item_addr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // word capture and commit payload (no reset)
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r    <= in_operation;
      idx_r   <= in_facility_index;
      cap_r   <= in_capacity[CW-1:0];
      ocost_r <= in_opening_cost[CW-1:0];
      dem_r   <= in_demand;
      acost_r <= in_assign_cost[CW-1:0];
      last_r  <= in_last_in_row;
    end
    if (cmd.commit) begin
      charge_r <= (CW + 1)'(best_cost_r) + (rd_open ? '0 : (CW + 1)'(rd_ocost));
      opened_r <= !rd_open;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_cost_r  <= '1;
      best_index_r <= '0;
      best_valid_r <= 1'b0;
      total_r      <= '0;
      sweep_cnt_r  <= '0;
    end else begin
      if (cmd.sweep) begin
        sweep_cnt_r <= sweep_cnt_r + AW'(1);
      end
      if (cmd.start || cmd.emit) begin
        best_cost_r  <= '1;
        best_index_r <= '0;
        best_valid_r <= 1'b0;
      end else if (cmd.eval && fits && better) begin
        best_cost_r  <= acost_r;
        best_index_r <= item_addr;
        best_valid_r <= 1'b1;
      end
      if (cmd.start) begin
        total_r <= '0;
      end else if (cmd.emit && best_valid_r) begin
        total_r <= total_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (best_valid_r) begin
        out_chosen_r  <= gca_pkg::IDX_W'(best_index_r);
        out_found_r   <= 1'b1;
        out_charged_r <= gca_pkg::CHG_W'(charge_r);
        out_opened_r  <= opened_r;
        out_total_r   <= total_new;
      end else begin
        out_chosen_r  <= '0;
        out_found_r   <= 1'b0;
        out_charged_r <= '0;
        out_opened_r  <= 1'b0;
        out_total_r   <= total_r;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_chosen_facility = out_chosen_r;
  assign out_found           = out_found_r;
  assign out_charged_cost    = out_charged_r;
  assign out_newly_opened    = out_opened_r;
  assign out_total_cost      = out_total_r;

  assign st.op         = op_r;
  assign st.last       = last_r;
  assign st.sweep_last = (sweep_cnt_r == AW'(FACILITY_SLOTS - 1));
  assign st.out_busy   = out_valid_r && out_stall;

  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.emit))
    else $error("result valid without emit");

  a_nofit_total_kept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && !best_valid_r |=> !out_found_r && out_total_r == $past(total_r))
    else $error("unfitted customer changed total");

endmodule

`default_nettype wire

// File: test/greedy_capacitated_assigner_top_tb.sv
// Self-checking testbench for greedy_capacitated_assigner_top.
// Drives start, load and cost words and checks every result word against an in-bench
// assignment predictor or typed-in result. Depends on gca_pkg and the RTL top only.
`timescale 1ns / 1ps

module greedy_capacitated_assigner_top_tb;

  localparam int OP_W  = gca_pkg::OP_W;
  localparam int IDX_W = gca_pkg::IDX_W;
  localparam int FLD_W = gca_pkg::FLD_W;
  localparam int DEM_W = gca_pkg::DEM_W;
  localparam int CHG_W = gca_pkg::CHG_W;
  localparam int TOT_W = gca_pkg::TOT_W;

  localparam int          SLOTS       = 64;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          DRAIN       = 16;
  localparam int          RAND_ITEMS  = 550;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;  // unused code, block ignores it

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    logic [FLD_W-1:0] cap;
    logic [FLD_W-1:0] ocost;
    logic [DEM_W-1:0] dem;
    logic [FLD_W-1:0] acost;
    logic             last;
  } word_t;

  typedef struct packed {
    logic [IDX_W-1:0] fac;
    logic             found;
    logic [CHG_W-1:0] charge;
    logic             opened;
    logic [TOT_W-1:0] total;
  } assign_rec_t;

  typedef struct packed {
    word_t       w;
    logic        lit;  // expected result typed into the table
    assign_rec_t r;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_W-1:0]  in_operation = gca_pkg::OP_START;
  logic [IDX_W-1:0] in_facility_index = '0;
  logic [FLD_W-1:0] in_capacity = '0;
  logic [FLD_W-1:0] in_opening_cost = '0;
  logic [DEM_W-1:0] in_demand = '0;
  logic [FLD_W-1:0] in_assign_cost = '0;
  logic             in_last_in_row = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [IDX_W-1:0] out_chosen_facility;
  logic             out_found;
  logic [CHG_W-1:0] out_charged_cost;
  logic             out_newly_opened;
  logic [TOT_W-1:0] out_total_cost;

  greedy_capacitated_assigner_top u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_facility_index   (in_facility_index),
    .in_capacity         (in_capacity),
    .in_opening_cost     (in_opening_cost),
    .in_demand           (in_demand),
    .in_assign_cost      (in_assign_cost),
    .in_last_in_row      (in_last_in_row),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_chosen_facility (out_chosen_facility),
    .out_found           (out_found),
    .out_charged_cost    (out_charged_cost),
    .out_newly_opened    (out_newly_opened),
    .out_total_cost      (out_total_cost)
  );

  always #5 clk = ~clk;

  // Predictor state: facility stores, row search, running total.
  logic [FLD_W-1:0] cap_left  [SLOTS];
  logic [FLD_W-1:0] open_cost [SLOTS];
  bit               fac_open  [SLOTS];
  bit               loaded    [SLOTS];  // slot written by a load since the run began
  logic [FLD_W-1:0] best_cost = '1;
  logic [IDX_W-1:0] best_idx  = '0;
  bit               best_ok   = 1'b0;
  logic [TOT_W-1:0] run_total = '0;

  assign_rec_t pending_assignments[$];
  dir_row_t    dir_tab[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count    = 0;
  int unsigned fail_count     = 0;
  int unsigned words_sent     = 0;
  int unsigned results_seen   = 0;
  int unsigned misses_seen    = 0;
  int unsigned opens_seen     = 0;

  function automatic void clear_row_search();
    best_cost = '1;
    best_idx  = '0;
    best_ok   = 1'b0;
  endfunction

  // Advances the predictor by one accepted word; returns 1 when it yields a result.
  function automatic bit predict_assignment(input word_t w, output assign_rec_t r);
    logic [CHG_W-1:0] charge;
    logic [TOT_W:0]   sum;
    bit               opened;
    r = '0;
    predict_assignment = 1'b0;
    case (w.op)
      gca_pkg::OP_START: begin
        run_total = '0;
        clear_row_search();
      end
      gca_pkg::OP_LOAD: begin
        cap_left[w.idx]  = w.cap;
        open_cost[w.idx] = w.ocost;
        fac_open[w.idx]  = 1'b0;
        loaded[w.idx]    = 1'b1;
      end
      gca_pkg::OP_COST: begin
        // strict compare: the earlier element keeps a tie
        if (cap_left[w.idx] >= w.dem && (!best_ok || w.acost < best_cost)) begin
          best_cost = w.acost;
          best_idx  = w.idx;
          best_ok   = 1'b1;
        end
        if (w.last) begin
          predict_assignment = 1'b1;
          if (best_ok) begin
            opened = !fac_open[best_idx];
            charge = {1'b0, best_cost} + (opened ? {1'b0, open_cost[best_idx]} : '0);
            fac_open[best_idx] = 1'b1;
            // a load during the row can leave less than the demand
            cap_left[best_idx] = (cap_left[best_idx] >= w.dem) ?
                                 cap_left[best_idx] - w.dem : '0;
            sum = {1'b0, run_total} + charge;
            run_total = sum[TOT_W] ? '1 : sum[TOT_W-1:0];
            r.fac    = best_idx;
            r.found  = 1'b1;
            r.charge = charge;
            r.opened = opened;
          end
          r.total = run_total;
          clear_row_search();
        end
      end
      default: ;
    endcase
  endfunction

  function automatic dir_row_t dir_row(input logic [OP_W-1:0] op, input int unsigned idx,
                                       input int unsigned cap, ocost, dem, acost,
                                       input bit last, lit, input int unsigned fac,
                                       input bit found, input int unsigned charge,
                                       input bit opened, input logic [31:0] total);
    dir_row_t d;
    d.w = '{op: op, idx: idx[IDX_W-1:0], cap: cap[FLD_W-1:0], ocost: ocost[FLD_W-1:0],
            dem: dem[DEM_W-1:0], acost: acost[FLD_W-1:0], last: last};
    d.lit = lit;
    d.r = '{fac: fac[IDX_W-1:0], found: found, charge: charge[CHG_W-1:0],
            opened: opened, total: total};
    return d;
  endfunction

  // Appends one stimulus row to the directed table.
  function automatic void add_row(input dir_row_t d);
    dir_tab.insert(dir_tab.size(), d);
  endfunction

  function automatic logic [FLD_W-1:0] rand_cost();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 10) return '0;
    if (p < 20) return '1;
    return FLD_W'($urandom_range(0, 20'hFFFFF));
  endfunction

  function automatic logic [FLD_W-1:0] rand_capacity();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 15) return '0;
    if (p < 30) return '1;
    return FLD_W'($urandom_range(0, 300000));
  endfunction

  function automatic logic [DEM_W-1:0] rand_demand();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 15) return '0;
    if (p < 25) return '1;
    if (p < 35) return DEM_W'($urandom_range(0, 16'hFFFF));
    return DEM_W'($urandom_range(0, 20000));
  endfunction

  function automatic word_t rand_word();
    word_t w;
    w.op    = OP_SPARE;
    w.idx   = IDX_W'($urandom_range(0, SLOTS - 1));
    w.cap   = rand_cost();
    w.ocost = rand_cost();
    w.dem   = rand_demand();
    w.acost = rand_cost();
    w.last  = 1'($urandom_range(0, 1));
    return w;
  endfunction

  // Cost words may only name slots that a load has written.
  function automatic logic [IDX_W-1:0] pick_loaded();
    logic [IDX_W-1:0] i;
    i = IDX_W'($urandom_range(0, SLOTS - 1));
    while (!loaded[i]) i = IDX_W'($urandom_range(0, SLOTS - 1));
    return i;
  endfunction

  // Offers one word, holds it until taken, then updates the predictor.
  task automatic send_word(input word_t w, input bit lit, input assign_rec_t lit_r);
    assign_rec_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_operation      <= w.op;
    in_facility_index <= w.idx;
    in_capacity       <= w.cap;
    in_opening_cost   <= w.ocost;
    in_demand         <= w.dem;
    in_assign_cost    <= w.acost;
    in_last_in_row    <= w.last;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (predict_assignment(w, r)) begin
      pending_assignments.insert(pending_assignments.size(), lit ? lit_r : r);
    end
    words_sent++;
  endtask

  task automatic send_load();
    word_t w;
    w = rand_word();
    w.op  = gca_pkg::OP_LOAD;
    w.cap = rand_capacity();
    send_word(w, 1'b0, '0);
  endtask

  // Sender holds off until every outstanding result has been taken.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_assignments.size() != 0);
  endtask

  // Mostly well-formed customer rows over loaded slots, with loads, restarts
  // and stray words mixed in.
  task automatic run_random(input int unsigned n_items);
    int unsigned done_items, len, p;
    logic [DEM_W-1:0] dem;
    word_t w;
    done_items = 0;
    while (done_items < n_items) begin
      p = $urandom_range(0, 99);
      if (p < 6) begin
        w = rand_word();
        w.op = gca_pkg::OP_START;
        send_word(w, 1'b0, '0);
        done_items++;
      end else if (p < 22) begin
        repeat ($urandom_range(1, 3)) begin
          send_load();
          done_items++;
        end
      end else if (p < 92) begin
        dem = rand_demand();
        len = $urandom_range(1, 6);
        for (int unsigned i = 0; i < len; i++) begin
          p = $urandom_range(0, 99);
          if (p < 3) begin
            send_load();
            done_items++;
          end else if (p < 5) begin
            w = rand_word();
            w.op = gca_pkg::OP_START;
            send_word(w, 1'b0, '0);
            done_items++;
          end
          w = rand_word();
          w.op   = gca_pkg::OP_COST;
          w.idx  = pick_loaded();
          w.dem  = ($urandom_range(0, 99) < 3) ? rand_demand() : dem;
          w.last = (i == len - 1);
          send_word(w, 1'b0, '0);
          done_items++;
        end
      end else begin
        w = rand_word();
        if ($urandom_range(0, 1)) begin
          send_word(w, 1'b0, '0);  // unused code, does not count
        end else begin
          w.op   = gca_pkg::OP_COST;
          w.idx  = pick_loaded();
          w.last = 1'b0;
          send_word(w, 1'b0, '0);
          done_items++;
        end
      end
    end
  endtask

  // Result checker and receiver stall generator.
  always @(posedge clk) begin : result_check
    assign_rec_t want, got;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = '{fac: out_chosen_facility, found: out_found, charge: out_charged_cost,
              opened: out_newly_opened, total: out_total_cost};
      results_seen++;
      if (pending_assignments.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result word: fac %0d found %0b charge %0d opened %0b total %0d",
                   got.fac, got.found, got.charge, got.opened, got.total);
      end else begin
        want = pending_assignments.pop_front();
        if (got.fac !== want.fac || got.found !== want.found ||
            got.charge !== want.charge || got.opened !== want.opened ||
            got.total !== want.total) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("result %0d mismatch", results_seen);
            $display("  exp: fac %0d found %0b charge %0d opened %0b total %0d",
                     want.fac, want.found, want.charge, want.opened, want.total);
            $display("  got: fac %0d found %0b charge %0d opened %0b total %0d",
                     got.fac, got.found, got.charge, got.opened, got.total);
          end
        end
        if (!want.found) misses_seen++;
        if (want.opened) opens_seen++;
      end
    end
    out_stall <= rst_n ? ($urandom_range(0, 99) < recv_stall_pct) : 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_assignments.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    for (int i = 0; i < SLOTS; i++) begin
      fac_open[i] = 1'b0;
      loaded[i]   = 1'b0;
    end

    //              op                 idx cap      ocost    dem      acost    lt lit
    //              fac found charge     opened total
    add_row(dir_row(gca_pkg::OP_START, 0,  0,       0,       0,       0,       0, 0,
                    0, 0, 0, 0, 0));
    add_row(dir_row(gca_pkg::OP_LOAD,  0,  100,     50,      0,       0,       0, 0,
                    0, 0, 0, 0, 0));
    add_row(dir_row(gca_pkg::OP_LOAD,  63, 'hFFFFF, 'hFFFFF, 0,       0,       0, 0,
                    0, 0, 0, 0, 0));
    add_row(dir_row(gca_pkg::OP_LOAD,  1,  0,       0,       0,       0,       0, 0,
                    0, 0, 0, 0, 0));
    // tie between slot 0 and 63; slot 1 has no room
    add_row(dir_row(gca_pkg::OP_COST,  0,  0,       0,       10,      5,       0, 0,
                    0, 0, 0, 0, 0));
    add_row(dir_row(gca_pkg::OP_COST,  63, 0,       0,       10,      5,       0, 0,
                    0, 0, 0, 0, 0));
    add_row(dir_row(gca_pkg::OP_COST,  1,  0,       0,       10,      0,       1, 1,
                    0, 1, 55, 1, 55));
    // already open: no opening charge
    add_row(dir_row(gca_pkg::OP_COST,  0,  0,       0,       10,      7,       1, 1,
                    0, 1, 7, 0, 62));
    // nothing fits
    add_row(dir_row(gca_pkg::OP_COST,  1,  0,       0,       1,       3,       1, 1,
                    0, 0, 0, 0, 62));
    // first fit taken even at all-ones cost
    add_row(dir_row(gca_pkg::OP_COST,  1,  0,       0,       0,       'hFFFFF, 0, 0,
                    0, 0, 0, 0, 0));
    add_row(dir_row(gca_pkg::OP_COST,  63, 0,       0,       0,       'hFFFFF, 1, 1,
                    1, 1, 'hFFFFF, 1, 1048637));
    add_row(dir_row(OP_SPARE,          5,  'hFFFFF, 'hFFFFF, 'hFFFF,  'hFFFFF, 1, 0,
                    0, 0, 0, 0, 0));
    // reload of the chosen slot mid-row: reopened, capacity clamps at zero
    add_row(dir_row(gca_pkg::OP_COST,  63, 0,       0,       'hFFFF,  'hFFFFF, 0, 0,
                    0, 0, 0, 0, 0));
    add_row(dir_row(gca_pkg::OP_LOAD,  63, 5,       'hFFFFF, 0,       0,       0, 0,
                    0, 0, 0, 0, 0));
    add_row(dir_row(gca_pkg::OP_COST,  0,  0,       0,       'hFFFF,  0,       1, 1,
                    63, 1, 'h1FFFFE, 1, 3145787));
    // start in the middle of a row drops the partial search
    add_row(dir_row(gca_pkg::OP_COST,  0,  0,       0,       0,       1,       0, 0,
                    0, 0, 0, 0, 0));
    add_row(dir_row(gca_pkg::OP_START, 0,  0,       0,       0,       0,       0, 0,
                    0, 0, 0, 0, 0));
    add_row(dir_row(gca_pkg::OP_COST,  0,  0,       0,       0,       2,       1, 1,
                    0, 1, 2, 0, 2));
    // exact fit, then the emptied slot refuses
    add_row(dir_row(gca_pkg::OP_LOAD,  2,  1000,    300,     0,       0,       0, 0,
                    0, 0, 0, 0, 0));
    add_row(dir_row(gca_pkg::OP_COST,  2,  0,       0,       1000,    9,       0, 0,
                    0, 0, 0, 0, 0));
    add_row(dir_row(gca_pkg::OP_COST,  0,  0,       0,       1000,    9,       1, 0,
                    0, 0, 0, 0, 0));
    add_row(dir_row(gca_pkg::OP_COST,  2,  0,       0,       1,       0,       1, 0,
                    0, 0, 0, 0, 0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) send_word(dir_tab[i].w, dir_tab[i].lit, dir_tab[i].r);
    hold_until_drained();

    // Random traffic under four idling patterns.
    send_idle_pct = 0;  recv_stall_pct = 0;
    run_random(RAND_ITEMS / 4);
    hold_until_drained();
    send_idle_pct = 67; recv_stall_pct = 0;
    run_random(RAND_ITEMS / 4);
    hold_until_drained();
    send_idle_pct = 0;  recv_stall_pct = 67;
    run_random(RAND_ITEMS / 4);
    hold_until_drained();
    send_idle_pct = 8;  recv_stall_pct = 8;
    run_random(RAND_ITEMS / 4);

    in_valid <= 1'b0;
    while (pending_assignments.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("%0d words sent, %0d results checked (%0d not found, %0d openings)",
             words_sent, results_seen, misses_seen, opens_seen);
    $display("directed edge rows plus random rows under four stall mixes, %0d failures",
             fail_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/gca_pkg.sv
rtl/gca_ctrl.sv
rtl/gca_datapath.sv
rtl/greedy_capacitated_assigner_top.sv
test/greedy_capacitated_assigner_top_tb.sv
